FILE: sv/mrrf_pkg.sv
// Shared types, constants and helper functions for the request framer.
package mrrf_pkg;

    localparam int HDR_BYTES   = 6;
    localparam int BODY_BYTES  = 6;
    localparam int CRC_BYTES   = 2;
    localparam int FRAME_BYTES = HDR_BYTES + BODY_BYTES + CRC_BYTES;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int REQ_DATA_W  = 48;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Byte positions inside the frame
    localparam logic [IDX_W-1:0] IDX_BODY_FIRST = IDX_W'(HDR_BYTES);
    localparam logic [IDX_W-1:0] IDX_CRC_LO     = IDX_W'(HDR_BYTES + BODY_BYTES);
    localparam logic [IDX_W-1:0] IDX_CRC_HI     = IDX_W'(HDR_BYTES + BODY_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST       = IDX_W'(FRAME_BYTES - 1);

    typedef logic [IDX_W-1:0] byte_idx_t;

    // Body bytes in transmit order, body[0] goes out first
    typedef struct packed {
        logic [BODY_BYTES-1:0][7:0] body;
    } req_t;

    // Fixed ASCII header
    function automatic logic [7:0] hdr_byte(input byte_idx_t idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h42;
            4'd1:    b = 8'h55;
            4'd2:    b = 8'h53;
            4'd3:    b = 8'h42;
            4'd4:    b = 8'h41;
            4'd5:    b = 8'h52;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // One byte of reflected CRC-16, bit by bit
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: sv/modbus_rtu_request_framer.sv
// Top level: Modbus RTU request framer with fixed header and CRC-16 trailer.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: address, function, register, count
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: frame byte, tlast: final byte
//
// Each request yields 14 output transactions, one per cycle when m_axis_tready
// stays high, and frames follow back to back, since the next request is taken
// as the last byte goes out. A two-entry request queue lets s_axis take new
// requests while a frame is still being sent. An accepted request passes through
// the queue, the serializer's frame state and the output register before its
// first byte appears. Reset (rst_n low) empties the queue and drops any frame in
// progress. Output stalls hold the current byte and back up into the queue.
module modbus_rtu_request_framer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // device_address[7:0], function_code[15:8], register_address[31:16],
    // register_count[47:32]
    input  logic [mrrf_pkg::REQ_DATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]                        m_axis_tdata,
    output logic                              m_axis_tlast
);
    import mrrf_pkg::*;

    logic req_valid;
    logic req_pop;
    req_t req;

    mrrf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .req_valid     (req_valid),
        .req_pop       (req_pop),
        .req           (req)
    );

    mrrf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_pop       (req_pop),
        .req           (req),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: sv/mrrf_front.sv
// Request intake: unpacks the request into body bytes and queues it.
module mrrf_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // device_address[7:0], function_code[15:8], register_address[31:16],
    // register_count[47:32]
    input  logic [mrrf_pkg::REQ_DATA_W-1:0]   s_axis_tdata,
    output logic                              req_valid,
    input  logic                              req_pop,
    output mrrf_pkg::req_t                    req
);
    import mrrf_pkg::*;

    req_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    req_t              in_req;
    logic              push;
    logic              pop;

    // Register fields go out high byte first
    always_comb
    begin
        in_req.body[0] = s_axis_tdata[7:0];
        in_req.body[1] = s_axis_tdata[15:8];
        in_req.body[2] = s_axis_tdata[31:24];
        in_req.body[3] = s_axis_tdata[23:16];
        in_req.body[4] = s_axis_tdata[47:40];
        in_req.body[5] = s_axis_tdata[39:32];
    end

    assign s_axis_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign req_valid     = (count_reg != '0);
    assign pop           = req_pop && req_valid;
    assign req           = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= in_req;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        req_pop |-> req_valid)
        else $error("pop from empty queue");

endmodule

FILE: sv/mrrf_back.sv
// Frame serializer: emits header, body and CRC one byte per transaction.
module mrrf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_pop,
    input  mrrf_pkg::req_t req,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]     m_axis_tdata,
    output logic           m_axis_tlast
);
    import mrrf_pkg::*;

    logic        busy_reg, busy_next;
    byte_idx_t   idx_reg, idx_next;
    req_t        req_reg;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        advance;
    logic        emit;
    logic        in_body;
    logic [7:0]  body_byte;
    logic [7:0]  cur_byte;
    byte_idx_t   body_sel;

    assign advance = !out_valid_reg || m_axis_tready;
    assign emit    = busy_reg && advance;
    // Next request is taken while the last byte of the current one goes out
    assign req_pop = req_valid && (!busy_reg || (emit && idx_reg == IDX_LAST));

    assign in_body   = (idx_reg >= IDX_BODY_FIRST) && (idx_reg < IDX_CRC_LO);
    assign body_sel  = idx_reg - IDX_BODY_FIRST;
    assign body_byte = req_reg.body[body_sel[$clog2(BODY_BYTES)-1:0]];

    always_comb
    begin
        priority if (idx_reg < IDX_BODY_FIRST)
            cur_byte = hdr_byte(idx_reg);
        else if (in_body)
            cur_byte = body_byte;
        else if (idx_reg == IDX_CRC_LO)
            cur_byte = crc_reg[7:0];
        else
            cur_byte = crc_reg[15:8];
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = busy_reg;
        if (emit)
        begin
            idx_next = idx_reg + 1'b1;
            if (in_body)
                crc_next = crc_byte(crc_reg, body_byte);
            if (idx_reg == IDX_LAST)
                busy_next = 1'b0;
        end
        if (req_pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            crc_next  = CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (req_pop)
            req_reg <= req;
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= (idx_reg == IDX_LAST);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= IDX_LAST))
        else $error("byte index past end of frame");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && idx_reg == IDX_LAST) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("final byte not marked");

    a_pop_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (req_pop && busy_reg) |-> (emit && idx_reg == IDX_LAST))
        else $error("request taken in the middle of a frame");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !busy_reg) |=> !m_axis_tvalid)
        else $error("output valid without an active frame");

endmodule
